>>> src/ilr_pkg.sv
// ----------------------------------------------------------------------------
// ilr_pkg
// Shared types and constants of the integer line rasteriser.
// ----------------------------------------------------------------------------
package ilr_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } ilr_op_t;

  localparam int unsigned COLOR_WIDTH = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

>>> src/ilr_front.sv
// ----------------------------------------------------------------------------
// ilr_front
// Classifies incoming transactions and prepares the line set-up for a start:
// steepness, endpoint ordering along the major axis and the two spans.
// ----------------------------------------------------------------------------
module ilr_front import ilr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 10
) (
  input  logic                   in_opcode,
  input  logic [COORD_WIDTH-1:0] in_start_x,
  input  logic [COORD_WIDTH-1:0] in_start_y,
  input  logic [COORD_WIDTH-1:0] in_end_x_in,
  input  logic [COORD_WIDTH-1:0] in_end_y_in,
  output ilr_op_t                fe_op,
  output logic [COORD_WIDTH-1:0] fe_major_start,
  output logic [COORD_WIDTH-1:0] fe_minor_start,
  output logic [COORD_WIDTH-1:0] fe_major_end,
  output logic [COORD_WIDTH-1:0] fe_major_span,
  output logic [COORD_WIDTH:0]   fe_minor_span_twice,
  output logic                   fe_minor_down,
  output logic                   fe_steep
);

  logic [COORD_WIDTH-1:0] span_x;
  logic [COORD_WIDTH-1:0] span_y;
  logic [COORD_WIDTH-1:0] a0, b0, a1, b1;
  logic [COORD_WIDTH-1:0] minor_end;
  logic [COORD_WIDTH-1:0] minor_span;
  logic                   swap;

  always_comb begin
    span_x   = (in_start_x > in_end_x_in) ? (in_start_x - in_end_x_in)
                                          : (in_end_x_in - in_start_x);
    span_y   = (in_start_y > in_end_y_in) ? (in_start_y - in_end_y_in)
                                          : (in_end_y_in - in_start_y);
    fe_steep = (span_y > span_x);
    if (fe_steep) begin
      a0 = in_start_y;
      b0 = in_start_x;
      a1 = in_end_y_in;
      b1 = in_end_x_in;
    end else begin
      a0 = in_start_x;
      b0 = in_start_y;
      a1 = in_end_x_in;
      b1 = in_end_y_in;
    end
    swap           = (a0 > a1);
    fe_major_start = swap ? a1 : a0;
    fe_minor_start = swap ? b1 : b0;
    fe_major_end   = swap ? a0 : a1;
    minor_end      = swap ? b0 : b1;
    fe_major_span  = fe_major_end - fe_major_start;
    fe_minor_down  = (minor_end < fe_minor_start);
    minor_span     = fe_minor_down ? (fe_minor_start - minor_end)
                                   : (minor_end - fe_minor_start);
    fe_minor_span_twice = {minor_span, 1'b0};
    fe_op          = ilr_op_t'(in_opcode);
  end

endmodule

>>> src/ilr_queue.sv
// ----------------------------------------------------------------------------
// ilr_queue
// Short first-in first-out queue that decouples the front from the walker.
// ----------------------------------------------------------------------------
module ilr_queue import ilr_pkg::*; #(
  parameter int unsigned WIDTH = 54,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    push_ready = (count_r != CNT_W'(DEPTH));
    pop_valid  = (count_r != '0);
    pop_data   = entry_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop && pop_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy exceeds its depth");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push && count_r == CNT_W'(1)) |=> !pop_valid)
    else $error("queue still valid after its last entry left");

endmodule

>>> src/ilr_back.sv
// ----------------------------------------------------------------------------
// ilr_back
// Line walker: loads a prepared line on a start and emits one pixel per step
// into an output register, advancing the error term by one add and compare.
// ----------------------------------------------------------------------------
module ilr_back import ilr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [COLOR_WIDTH-1:0] cfg_wr_data,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  ilr_op_t                q_op,
  input  logic [COORD_WIDTH-1:0] q_major_start,
  input  logic [COORD_WIDTH-1:0] q_minor_start,
  input  logic [COORD_WIDTH-1:0] q_major_end,
  input  logic [COORD_WIDTH-1:0] q_major_span,
  input  logic [COORD_WIDTH:0]   q_minor_span_twice,
  input  logic                   q_minor_down,
  input  logic                   q_steep,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] out_pixel_x,
  output logic [COORD_WIDTH-1:0] out_pixel_y,
  output logic [COLOR_WIDTH-1:0] out_pixel_color,
  output logic                   out_last_pixel
);

  localparam int unsigned ERR_W = COORD_WIDTH + 2;

  logic [COLOR_WIDTH-1:0]  draw_color_r;
  logic                    busy_r, busy_nxt;
  logic                    steep_r, steep_nxt;
  logic [COORD_WIDTH-1:0]  major_pos_r, major_pos_nxt;
  logic [COORD_WIDTH-1:0]  minor_pos_r, minor_pos_nxt;
  logic [COORD_WIDTH-1:0]  major_end_r, major_end_nxt;
  logic [COORD_WIDTH-1:0]  major_span_r, major_span_nxt;
  logic [COORD_WIDTH:0]    minor_span_twice_r, minor_span_twice_nxt;
  logic                    minor_down_r, minor_down_nxt;
  logic signed [ERR_W-1:0] error_r, error_nxt;
  logic signed [ERR_W:0]   err_sum;
  logic signed [ERR_W:0]   err_dec;
  logic signed [ERR_W:0]   span_ext;
  logic                    out_valid_r, out_valid_nxt;
  logic [COORD_WIDTH-1:0]  out_x_r, out_x_nxt;
  logic [COORD_WIDTH-1:0]  out_y_r, out_y_nxt;
  logic [COLOR_WIDTH-1:0]  out_color_r, out_color_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_free;
  logic                    emit;
  logic                    last;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    q_pop    = q_valid && ((q_op == OP_START) || !busy_r || out_free);
    emit     = q_pop && (q_op == OP_STEP) && busy_r;
    last     = (major_pos_r == major_end_r);
    span_ext = $signed({3'b000, major_span_r});
    err_sum  = $signed({error_r[ERR_W-1], error_r}) + $signed({2'b00, minor_span_twice_r});
    err_dec  = err_sum - (span_ext <<< 1);

    busy_nxt             = busy_r;
    steep_nxt            = steep_r;
    major_pos_nxt        = major_pos_r;
    minor_pos_nxt        = minor_pos_r;
    major_end_nxt        = major_end_r;
    major_span_nxt       = major_span_r;
    minor_span_twice_nxt = minor_span_twice_r;
    minor_down_nxt       = minor_down_r;
    error_nxt            = error_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;

    if (q_pop && (q_op == OP_START)) begin
      busy_nxt             = 1'b1;
      steep_nxt            = q_steep;
      major_pos_nxt        = q_major_start;
      minor_pos_nxt        = q_minor_start;
      major_end_nxt        = q_major_end;
      major_span_nxt       = q_major_span;
      minor_span_twice_nxt = q_minor_span_twice;
      minor_down_nxt       = q_minor_down;
      error_nxt            = '0;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = steep_r ? minor_pos_r : major_pos_r;
      out_y_nxt     = steep_r ? major_pos_r : minor_pos_r;
      out_color_nxt = draw_color_r;
      out_last_nxt  = last;
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        major_pos_nxt = major_pos_r + 1'b1;
        if (err_sum >= span_ext) begin
          minor_pos_nxt = minor_down_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
          error_nxt     = $signed(err_dec[ERR_W-1:0]);
        end else begin
          error_nxt = $signed(err_sum[ERR_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_color_r <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        draw_color_r <= cfg_wr_data;
      end
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steep_r            <= steep_nxt;
    major_pos_r        <= major_pos_nxt;
    minor_pos_r        <= minor_pos_nxt;
    major_end_r        <= major_end_nxt;
    major_span_r       <= major_span_nxt;
    minor_span_twice_r <= minor_span_twice_nxt;
    minor_down_r       <= minor_down_nxt;
    error_r            <= error_nxt;
    out_x_r            <= out_x_nxt;
    out_y_r            <= out_y_nxt;
    out_color_r        <= out_color_nxt;
    out_last_r         <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_last_pixel  = out_last_r;

  a_last_ends_walk : assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> !busy_r)
    else $error("walker still busy after the final pixel");

  a_error_range : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((error_r >= -span_ext) && ((error_r < span_ext) || (span_ext == '0))))
    else $error("error term left its range");

  a_emit_needs_busy : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("pixel emitted without an active line");

endmodule

>>> src/integer_line_rasterizer.sv
// ----------------------------------------------------------------------------
// integer_line_rasterizer
// Bresenham line walker with a set-up front, a two-entry queue and a walker.
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle when the queue has room. A start
// transaction is ordered and measured in the front and loads the walker
// from the queue without producing a pixel; each step transaction then
// yields one pixel while a line is active, so a line of N pixels needs N+1
// input transactions. The walker advances the error term with a single add
// and compare per cycle, which sets the sustained rate at one pixel per
// clock unless the output stalls; a pixel passes the queue and the output
// register. The colour register may only be written while the block is idle.
module integer_line_rasterizer import ilr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [COLOR_WIDTH-1:0] cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_opcode,
  input  logic [COORD_WIDTH-1:0] in_start_x,
  input  logic [COORD_WIDTH-1:0] in_start_y,
  input  logic [COORD_WIDTH-1:0] in_end_x_in,
  input  logic [COORD_WIDTH-1:0] in_end_y_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] out_pixel_x,
  output logic [COORD_WIDTH-1:0] out_pixel_y,
  output logic [COLOR_WIDTH-1:0] out_pixel_color,
  output logic                   out_last_pixel
);

  localparam int unsigned QW = 5 * COORD_WIDTH + 4;

  ilr_op_t                fe_op;
  logic [COORD_WIDTH-1:0] fe_major_start;
  logic [COORD_WIDTH-1:0] fe_minor_start;
  logic [COORD_WIDTH-1:0] fe_major_end;
  logic [COORD_WIDTH-1:0] fe_major_span;
  logic [COORD_WIDTH:0]   fe_minor_span_twice;
  logic                   fe_minor_down;
  logic                   fe_steep;
  logic [QW-1:0]          push_data;
  logic [QW-1:0]          pop_data;
  logic                   q_valid;
  logic                   q_pop;

  ilr_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .in_opcode           (in_opcode),
    .in_start_x          (in_start_x),
    .in_start_y          (in_start_y),
    .in_end_x_in         (in_end_x_in),
    .in_end_y_in         (in_end_y_in),
    .fe_op               (fe_op),
    .fe_major_start      (fe_major_start),
    .fe_minor_start      (fe_minor_start),
    .fe_major_end        (fe_major_end),
    .fe_major_span       (fe_major_span),
    .fe_minor_span_twice (fe_minor_span_twice),
    .fe_minor_down       (fe_minor_down),
    .fe_steep            (fe_steep)
  );

  assign push_data = {fe_op, fe_major_start, fe_minor_start, fe_major_end,
                      fe_major_span, fe_minor_span_twice, fe_minor_down, fe_steep};

  ilr_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (pop_data)
  );

  ilr_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_op               (ilr_op_t'(pop_data[QW-1])),
    .q_major_start      (pop_data[QW-2 -: COORD_WIDTH]),
    .q_minor_start      (pop_data[QW-2-COORD_WIDTH -: COORD_WIDTH]),
    .q_major_end        (pop_data[QW-2-2*COORD_WIDTH -: COORD_WIDTH]),
    .q_major_span       (pop_data[QW-2-3*COORD_WIDTH -: COORD_WIDTH]),
    .q_minor_span_twice (pop_data[COORD_WIDTH+2:2]),
    .q_minor_down       (pop_data[1]),
    .q_steep            (pop_data[0]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_x        (out_pixel_x),
    .out_pixel_y        (out_pixel_y),
    .out_pixel_color    (out_pixel_color),
    .out_last_pixel     (out_last_pixel)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer line rasteriser. A queue of pending
// commands feeds a clocked driver, and a clocked monitor compares every pixel
// with a prediction made when its step transaction is accepted. A directed
// part covers endpoint extremes and the corner cases of the walk. Random
// line sequences then follow, under several colour settings and with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import ilr_pkg::*;

  localparam int unsigned CW = 10;

  typedef struct {
    ilr_op_t       op;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
  } line_cmd_t;

  typedef struct {
    logic [CW-1:0]          x;
    logic [CW-1:0]          y;
    logic [COLOR_WIDTH-1:0] color;
    logic                   last;
  } pixel_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [COLOR_WIDTH-1:0] cfg_wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_opcode = 1'b0;
  logic [CW-1:0]          in_start_x = '0;
  logic [CW-1:0]          in_start_y = '0;
  logic [CW-1:0]          in_end_x_in = '0;
  logic [CW-1:0]          in_end_y_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CW-1:0]          out_pixel_x;
  logic [CW-1:0]          out_pixel_y;
  logic [COLOR_WIDTH-1:0] out_pixel_color;
  logic                   out_last_pixel;

  integer_line_rasterizer #(.COORD_WIDTH(CW)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x_in    (in_end_x_in),
    .in_end_y_in    (in_end_y_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel)
  );

  line_cmd_t cmd_q[$];
  pixel_t    pixel_exp_q[$];
  line_cmd_t tx_cur;
  pixel_t    want;
  int        fault_count = 0;

  logic [COLOR_WIDTH-1:0] line_color = '0;
  logic                   ln_busy = 1'b0;
  logic                   ln_steep = 1'b0;
  logic [CW-1:0]          ln_major = '0;
  logic [CW-1:0]          ln_minor = '0;
  logic [CW-1:0]          ln_major_end = '0;
  logic [CW-1:0]          ln_major_span = '0;
  logic [CW:0]            ln_minor_twice = '0;
  logic                   ln_minor_down = 1'b0;
  int                     ln_err = 0;

  int tx_gap = 0;
  int tx_run = 0;
  bit tx_calm = 1'b0;
  int rx_gap = 0;
  int rx_run = 0;
  bit rx_calm = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [CW-1:0] span(logic [CW-1:0] a, logic [CW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int near(int base, int reach);
    int v;
    v = base + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  function automatic int next_pause(inout int run, inout bit calm);
    if (run == 0) begin
      run = $urandom_range(1, 40);
      calm = ($urandom_range(0, 2) == 0);
    end
    run--;
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic push_cmd(ilr_op_t op, int sx, int sy, int ex, int ey);
    line_cmd_t c;
    c.op = op;
    c.sx = sx[CW-1:0];
    c.sy = sy[CW-1:0];
    c.ex = ex[CW-1:0];
    c.ey = ey[CW-1:0];
    cmd_q.push_back(c);
  endtask

  task automatic push_step();
    push_cmd(OP_STEP, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic advance_line(line_cmd_t c);
    pixel_t        p;
    logic [CW-1:0] a0, b0, a1, b1, t;
    int            e;
    if (c.op == OP_START) begin
      ln_steep = span(c.sy, c.ey) > span(c.sx, c.ex);
      if (ln_steep) begin
        a0 = c.sy; b0 = c.sx; a1 = c.ey; b1 = c.ex;
      end else begin
        a0 = c.sx; b0 = c.sy; a1 = c.ex; b1 = c.ey;
      end
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      ln_major = a0;
      ln_minor = b0;
      ln_major_end = a1;
      ln_major_span = a1 - a0;
      ln_minor_twice = {1'b0, span(b0, b1)} << 1;
      ln_minor_down = b1 < b0;
      ln_err = 0;
      ln_busy = 1'b1;
      return;
    end
    if (!ln_busy) return;
    p.x = ln_steep ? ln_minor : ln_major;
    p.y = ln_steep ? ln_major : ln_minor;
    p.color = line_color;
    p.last = (ln_major == ln_major_end);
    pixel_exp_q.push_back(p);
    if (p.last) begin
      ln_busy = 1'b0;
      return;
    end
    e = ln_err + int'(ln_minor_twice);
    if (e >= int'(ln_major_span)) begin
      ln_minor = ln_minor_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
      e -= 2 * int'(ln_major_span);
    end
    ln_err = e;
    ln_major = ln_major + 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        advance_line(tx_cur);
        tx_gap = next_pause(tx_run, tx_calm);
        if (tx_gap == 0 && cmd_q.size() != 0) begin
          tx_cur = cmd_q.pop_front();
          in_opcode <= tx_cur.op;
          in_start_x <= tx_cur.sx;
          in_start_y <= tx_cur.sy;
          in_end_x_in <= tx_cur.ex;
          in_end_y_in <= tx_cur.ey;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (tx_gap > 1) begin
          tx_gap--;
        end else if (cmd_q.size() != 0) begin
          tx_gap = 0;
          tx_cur = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_opcode <= tx_cur.op;
          in_start_x <= tx_cur.sx;
          in_start_y <= tx_cur.sy;
          in_end_x_in <= tx_cur.ex;
          in_end_y_in <= tx_cur.ey;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pixel_exp_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("unexpected pixel: x=%0d y=%0d color=%h last=%0b",
                     out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel);
          end
        end else begin
          want = pixel_exp_q.pop_front();
          if (out_pixel_x !== want.x || out_pixel_y !== want.y ||
              out_pixel_color !== want.color || out_last_pixel !== want.last) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("pixel mismatch: expected x=%0d y=%0d color=%h last=%0b",
                       want.x, want.y, want.color, want.last);
              $display("                actual   x=%0d y=%0d color=%h last=%0b",
                       out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel);
            end
          end
        end
        rx_gap = next_pause(rx_run, rx_calm);
        out_ready <= (rx_gap == 0);
      end else if (!out_ready) begin
        if (rx_gap > 1) begin
          rx_gap--;
        end else begin
          rx_gap = 0;
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int                     ph, n, k, kind, reach, npix, nsteps, x0, y0, x1, y1, dx, dy;
    logic [COLOR_WIDTH-1:0] color;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (ph = 0; ph < 6; ph++) begin
      while (cmd_q.size() != 0 || in_valid || pixel_exp_q.size() != 0) @(posedge clk);
      repeat (10) @(posedge clk);
      case (ph)
        0: color = '1;
        1: color = '0;
        3: color = 32'h8000_0001;
        default: color = $urandom;
      endcase
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= color;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      line_color = color;
      if (ph == 0) begin
        push_cmd(OP_STEP, 1023, 1023, 1023, 1023);
        push_cmd(OP_START, 0, 0, 0, 0);
        push_cmd(OP_STEP, 0, 0, 0, 0);
        push_cmd(OP_STEP, 1023, 0, 1023, 0);
        push_cmd(OP_START, 1023, 1023, 1023, 1023);
        push_cmd(OP_STEP, 0, 1023, 0, 1023);
        push_cmd(OP_START, 1023, 0, 1020, 3);
        repeat (4) push_step();
        push_cmd(OP_START, 1023, 1010, 1020, 1019);
        repeat (3) push_step();
        push_cmd(OP_START, 0, 1023, 1023, 0);
        repeat (2) push_step();
        push_cmd(OP_START, 10, 20, 13, 20);
        repeat (5) push_step();
      end else begin
        n = 0;
        while (n < 370) begin
          kind = $urandom_range(0, 99);
          if (kind < 85) begin
            reach = ($urandom_range(0, 24) == 0) ? 255 : 12;
            x0 = $urandom_range(0, 1023);
            y0 = $urandom_range(0, 1023);
            x1 = near(x0, reach);
            y1 = near(y0, reach);
            push_cmd(OP_START, x0, y0, x1, y1);
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            npix = ((dx > dy) ? dx : dy) + 1;
            if (kind < 70) begin
              nsteps = npix + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
            end else begin
              nsteps = $urandom_range(0, npix - 1);
            end
            for (k = 0; k < nsteps; k++) push_step();
            n += 1 + nsteps;
          end else begin
            repeat ($urandom_range(1, 3)) begin
              push_cmd(ilr_op_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                       $urandom);
            end
          end
        end
      end
    end
    while (cmd_q.size() != 0 || in_valid || pixel_exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0 && pixel_exp_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
